[design/mhf_pkg.sv]
// shared types, constants and crc helpers for the multicast hash filter builder
// no dependencies; imported by every module of the block
package mhf_pkg;

    // address and crc geometry
    localparam int MAC_BYTES    = 6;
    localparam int MAC_W        = 48;
    localparam int CRC_W        = 32;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam int BUCKET_SHIFT = 26;
    localparam int BUCKET_W     = 6;

    // hash table layout
    localparam int TABLE_W      = 64;
    localparam int WORD_W       = 16;
    localparam int NUM_WORDS    = TABLE_W / WORD_W;

    // stream widths
    localparam int S_TDATA_W    = 48;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 72;
    localparam int M_TUSER_W    = 1;
    localparam int USER_VALID_BIT = 0;
    localparam int USER_START_BIT = 1;
    localparam int OUT_PAD_W    = M_TDATA_W - BUCKET_W - TABLE_W;

    // queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // classified request handed from front to back
    typedef struct packed {
        logic                start_new;
        logic                entry_valid;
        logic [BUCKET_W-1:0] bucket_index;
    } mhf_item_t;

    // byte idx of the address, zero past the field
    function automatic logic [7:0] get_byte(input logic [MAC_W-1:0] mac, input int idx);
        get_byte = 8'(mac >> (8 * idx));
    endfunction

    // one byte of crc, msb-first shift, data taken lsb-first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [7:0] data);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = crc_in;
        for (int j = 0; j < 8; j++) begin
            fb  = crc[CRC_W-1] ^ data[j];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        crc_byte = crc;
    endfunction

endpackage

[design/multicast_hash_filter_builder.sv]
// Multicast hash filter builder: each request carries one MAC address and builds up a 64-bucket
// filter table; a request with start_new clears the table first, and a request with entry_valid
// hashes the address (CRC-32, poly 04C11DB7, preset all ones, no final inversion, bytes 0 to 5)
// and sets the bucket named by CRC bits 31:26. Every request returns one result holding the
// bucket and the whole table. One request is accepted per clock cycle unless a full queue holds
// up the CRC pipeline; a request passes through the CRC pipeline, which folds in one address
// byte per stage, then through the queue and then the table and output register. A four-deep
// queue between the CRC pipeline and the table lets either side stall on its own.
// top level; depends on mhf_pkg, mhf_front, mhf_queue and mhf_back
module multicast_hash_filter_builder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [47:0] mac_address
    input  logic [mhf_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] entry_valid, [1] start_new
    input  logic [mhf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] bucket_index, [21:6] table_word0, [37:22] table_word1,
    // [53:38] table_word2, [69:54] table_word3, [71:70] zero
    output logic [mhf_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] bucket_set
    output logic [mhf_pkg::M_TUSER_W-1:0] m_tuser
);
    import mhf_pkg::*;

    logic      push_valid;
    logic      push_ready;
    mhf_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    mhf_item_t pop_item;

    // crc pipeline
    mhf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (push_valid),
        .q_ready  (push_ready),
        .q_item   (push_item)
    );

    // decoupling queue
    mhf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // table update and result register
    mhf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_item   (pop_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[design/mhf_front.sv]
// front end: accepts requests and runs the crc one byte per pipeline stage
// depends on mhf_pkg; feeds classified requests into mhf_queue
module mhf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mhf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [mhf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          q_valid,
    input  logic                          q_ready,
    output mhf_pkg::mhf_item_t            q_item
);
    import mhf_pkg::*;

    localparam int LAST = MAC_BYTES - 1;

    logic [MAC_BYTES-1:0] valid_reg;
    logic [CRC_W-1:0]     crc_reg   [MAC_BYTES];
    logic [MAC_W-1:0]     mac_reg   [MAC_BYTES];
    logic [MAC_BYTES-1:0] entry_reg;
    logic [MAC_BYTES-1:0] start_reg;
    logic                 adv;

    // whole pipe moves unless the last stage is held by a full queue
    assign adv      = !valid_reg[LAST] || q_ready;
    assign s_tready = adv;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < MAC_BYTES; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // crc stages, byte i folded in at stage i
    always_ff @(posedge aclk) begin
        if (adv) begin
            crc_reg[0]   <= crc_byte(CRC_PRESET, get_byte(s_tdata[MAC_W-1:0], 0));
            mac_reg[0]   <= s_tdata[MAC_W-1:0];
            entry_reg[0] <= s_tuser[USER_VALID_BIT];
            start_reg[0] <= s_tuser[USER_START_BIT];
            for (int i = 1; i < MAC_BYTES; i++) begin
                crc_reg[i]   <= crc_byte(crc_reg[i-1], get_byte(mac_reg[i-1], i));
                mac_reg[i]   <= mac_reg[i-1];
                entry_reg[i] <= entry_reg[i-1];
                start_reg[i] <= start_reg[i-1];
            end
        end
    end

    // classify: bucket from crc top bits, zero for an unused entry
    always_comb begin
        q_valid             = valid_reg[LAST];
        q_item.start_new    = start_reg[LAST];
        q_item.entry_valid  = entry_reg[LAST];
        q_item.bucket_index = entry_reg[LAST]
                            ? crc_reg[LAST][BUCKET_SHIFT +: BUCKET_W] : '0;
    end

endmodule

[design/mhf_queue.sv]
// short fifo decoupling the crc front end from the table back end
// depends on mhf_pkg for the request type and depth
module mhf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  mhf_pkg::mhf_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mhf_pkg::mhf_item_t pop_item
);
    import mhf_pkg::*;

    mhf_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/mhf_back.sv]
// back end: merges each request into the hash table and holds the result
// depends on mhf_pkg; drains mhf_queue and drives the result stream
module mhf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  mhf_pkg::mhf_item_t            q_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mhf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [mhf_pkg::M_TUSER_W-1:0] m_tuser
);
    import mhf_pkg::*;

    logic [TABLE_W-1:0]  table_reg;
    logic [TABLE_W-1:0]  table_next;
    logic                out_valid_reg;
    logic [BUCKET_W-1:0] out_bucket_reg;
    logic                out_set_reg;
    logic [TABLE_W-1:0]  out_table_reg;
    logic                take;

    // output register frees up when its result is taken
    assign q_ready = !out_valid_reg || m_tready;
    assign take    = q_valid && q_ready;

    // clear on start, then set the bucket bit of a valid entry
    always_comb begin
        table_next = q_item.start_new ? '0 : table_reg;
        if (q_item.entry_valid) begin
            table_next = table_next | (TABLE_W'(1) << q_item.bucket_index);
        end
    end

    // table state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                table_reg <= table_next;
            end
            if (q_ready) begin
                out_valid_reg <= q_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            out_bucket_reg <= q_item.bucket_index;
            out_set_reg    <= q_item.entry_valid;
            out_table_reg  <= table_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_table_reg, out_bucket_reg};
    assign m_tuser  = out_set_reg;

endmodule

[design/mhf_checker.sv]
// port-level checks on the multicast hash filter builder result stream
// depends on mhf_pkg; bound to multicast_hash_filter_builder below
module mhf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mhf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mhf_pkg::M_TUSER_W-1:0] m_tuser
);
    import mhf_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // unused entry reports bucket zero
    a_bucket_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[BUCKET_W-1:0] == '0)
        else $error("bucket nonzero for unused entry");

    // the reported bucket is set in the reported table
    a_bucket_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            ((m_tdata[BUCKET_W +: TABLE_W] >> m_tdata[BUCKET_W-1:0]) & TABLE_W'(1)) != '0)
        else $error("bucket bit missing from table");

endmodule

bind multicast_hash_filter_builder mhf_checker u_mhf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/multicast_hash_filter_builder_tb.sv]
// self-checking testbench for multicast_hash_filter_builder: directed table then random table builds
// keeps its own crc-32 bucket predictor and filter copy; depends on mhf_pkg and the top level
module multicast_hash_filter_builder_tb;

    import mhf_pkg::*;

    localparam int RUN_LIMIT      = 200000;
    localparam int NUM_RANDOM     = 500;
    localparam int CALM_FIRST     = 150;
    localparam int CALM_LAST      = 299;
    localparam int IDLE_PCT       = 19;
    localparam int DRAIN_CYCLES   = MAC_BYTES + 8;
    localparam int TDATA_WORD_LSB = BUCKET_W;

    // one filter result as the block should return it
    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic                hit;
        logic [TABLE_W-1:0]  filter_bits;
    } filter_result_t;

    // one directed request; expected result typed in only where checked_here is set
    typedef struct packed {
        logic [MAC_W-1:0]    mac;
        logic                valid;
        logic                start;
        logic                checked_here;
        logic [BUCKET_W-1:0] bucket;
        logic                hit;
        logic [TABLE_W-1:0]  filter_bits;
    } address_row_t;

    localparam int NUM_DIRECTED = 20;
    localparam address_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // invalid entry right after reset: empty filter
        '{48'h0000_0000_0000, 1'b0, 1'b0, 1'b1, 6'd0, 1'b0, 64'h0},
        // invalid entry with start, all-ones address
        '{48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd0, 1'b0, 64'h0},
        '{48'h0000_0000_0000, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'h0000_0000_0001, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'h8000_0000_0000, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        // ipv4 and ipv6 style multicast groups
        '{48'h0100_005E_0001, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'h0100_0000_3333, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'h5555_5555_5555, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        // same group again leaves the filter unchanged
        '{48'h0100_005E_0001, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        // invalid entry keeps the filter
        '{48'h1234_5678_9ABC, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        // clear then merge in one request
        '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'hDEAD_BEEF_0001, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        // invalid entry with start empties the filter
        '{48'h0000_0000_0000, 1'b0, 1'b1, 1'b1, 6'd0, 1'b0, 64'h0},
        '{48'h0000_0000_0000, 1'b0, 1'b0, 1'b1, 6'd0, 1'b0, 64'h0},
        '{48'hFFFF_FFFF_FFFE, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'h7FFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'h0000_0000_0080, 1'b1, 1'b1, 1'b0, 6'd0, 1'b0, 64'h0},
        '{48'h0100_0000_0000, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 64'h0}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    logic [TABLE_W-1:0]   model_filter = '0;
    logic [TABLE_W-1:0]   buckets_seen = '0;
    filter_result_t       filters_due[$];
    bit                   calm = 1'b0;
    int                   errors = 0;
    int                   results_seen = 0;
    int                   restarts = 0;
    int                   cycles = 0;

    multicast_hash_filter_builder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // crc-32 over the address bits in wire order: byte 0 first, each byte lsb first,
    // bytes past the field taken as zero, never more than eight bytes
    function automatic logic [CRC_W-1:0] address_crc(input logic [MAC_W-1:0] mac);
        logic [CRC_W-1:0] crc;
        logic             feedback;
        crc = CRC_PRESET;
        for (int i = 0; i < 8 * MAC_BYTES && i < 64; i++) begin
            feedback = crc[CRC_W-1] ^ ((i < MAC_W) ? mac[i] : 1'b0);
            crc      = {crc[CRC_W-2:0], 1'b0};
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // advance the filter copy by one request and return what the block should report
    function automatic filter_result_t merge_address(input logic [MAC_W-1:0] mac,
                                                     input logic valid, input logic start);
        filter_result_t res;
        logic [CRC_W-1:0] crc;
        res = '0;
        if (start) begin
            model_filter = '0;
        end
        if (valid) begin
            crc                      = address_crc(mac);
            res.bucket               = crc[CRC_W-1 -: BUCKET_W];
            res.hit                  = 1'b1;
            model_filter[res.bucket] = 1'b1;
            buckets_seen[res.bucket] = 1'b1;
        end
        res.filter_bits = model_filter;
        return res;
    endfunction

    // present one request, wait for acceptance, then queue its expected result
    task automatic send_address(input logic [MAC_W-1:0] mac, input logic valid,
                                input logic start, input bit typed,
                                input filter_result_t typed_result);
        filter_result_t       predicted;
        logic [S_TUSER_W-1:0] user_bits;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        user_bits                 = '0;
        user_bits[USER_VALID_BIT] = valid;
        user_bits[USER_START_BIT] = start;
        s_tvalid <= 1'b1;
        s_tdata  <= mac;
        s_tuser  <= user_bits;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = merge_address(mac, valid, start);
        if (start) begin
            restarts++;
        end
        filters_due.push_back(typed ? typed_result : predicted);
    endtask

    // one field compare, reported with time, expected and actual
    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // result side: random back-pressure and compare against the oldest expectation
    always @(posedge aclk) begin
        filter_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (filters_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual tdata %0h tuser %0h",
                         $time, m_tdata, m_tuser);
            end else begin
                want = filters_due.pop_front();
                check_field("bucket_index", 16'(want.bucket), 16'(m_tdata[BUCKET_W-1:0]));
                check_field("bucket_set", 16'(want.hit), 16'(m_tuser[0]));
                for (int w = 0; w < NUM_WORDS; w++) begin
                    check_field($sformatf("table_word%0d", w),
                                want.filter_bits[w*WORD_W +: WORD_W],
                                m_tdata[TDATA_WORD_LSB + w*WORD_W +: WORD_W]);
                end
            end
        end
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, filters_due.size());
            $display("multicast_hash_filter_builder_tb NOT OK");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        address_row_t     row;
        filter_result_t   typed_result;
        logic [MAC_W-1:0] mac;
        logic             valid;
        logic             start;
        int               run_left;
        run_left = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row                      = DIRECTED_ROWS[i];
            typed_result.bucket      = row.bucket;
            typed_result.hit         = row.hit;
            typed_result.filter_bits = row.filter_bits;
            send_address(row.mac, row.valid, row.start, row.checked_here, typed_result);
        end

        // random filter builds: mostly runs of valid addresses opened by a start
        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (n >= CALM_FIRST && n <= CALM_LAST);
            if (run_left == 0 && $urandom_range(99) < 85) begin
                run_left = $urandom_range(80, 1);
                start    = 1'b1;
            end else begin
                start    = ($urandom_range(99) < 4);
            end
            if (run_left > 0) begin
                run_left--;
                valid = ($urandom_range(99) < 90);
            end else begin
                valid = 1'($urandom_range(1));
            end
            mac = {16'($urandom), $urandom};
            // many entries use the ipv4 multicast prefix with a random group
            if ($urandom_range(99) < 30) begin
                mac[23:0] = 24'h5E_00_01;
            end
            send_address(mac, valid, start, 1'b0, '0);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // drain
        while (filters_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d directed, %0d random) and %0d results,",
                 NUM_DIRECTED + NUM_RANDOM, NUM_DIRECTED, NUM_RANDOM, results_seen);
        $display("with %0d filter restarts and %0d of 64 buckets hit, %0d errors",
                 restarts, $countones(buckets_seen), errors);
        if (errors == 0) begin
            $display("multicast_hash_filter_builder_tb OK");
        end else begin
            $display("multicast_hash_filter_builder_tb NOT OK");
        end
        $finish;
    end

endmodule
